/* sv/fixed_block_pool_allocator_defines.svh */
// assertion macros shared by the allocator files
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define FBPA_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FBPA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/fbpa_pkg.sv */
package fbpa_pkg;

   localparam int IDX_W       = 9;
   localparam int SIZE_W      = 16;
   localparam int REQ_SIZE_W  = 17;
   localparam int ALLOC_CNT_W = 32;
   localparam int BYTES_W     = 48;
   localparam int USAGE_W     = 24;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 16;

   localparam int POOL_DEPTH_DEF = 256;

   localparam logic [IDX_W-1:0]  NULL_IDX        = 9'd256;
   localparam logic [IDX_W-1:0]  USED_MAX        = 9'd511;
   localparam logic [SIZE_W-1:0] BLOCK_SIZE_RST  = 16'd64;
   localparam logic [IDX_W-1:0]  BLOCK_COUNT_RST = 9'd256;

   localparam logic [CSR_IDX_W-1:0] REG_BLOCK_SIZE  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BLOCK_COUNT = 1'd1;

   typedef enum logic [1:0] {
      CMD_ALLOC = 2'd0,
      CMD_FREE  = 2'd1,
      CMD_RESET = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_TOO_LARGE = 2'd1,
      ST_EMPTY     = 2'd2
   } status_type;

   typedef struct packed {
      logic             alloc;
      logic             free;
      logic             clear;
      logic [IDX_W-1:0] idx;
      logic [IDX_W-1:0] cnt;
   } fl_req_type;

   typedef struct packed {
      logic             granted;
      logic             pushed;
      logic [IDX_W-1:0] index;
   } fl_rsp_type;

endpackage

/* sv/fbpa_if.sv */
interface fbpa_req_if import fbpa_pkg::*; ();
   logic                  valid;
   logic                  ready;
   cmd_type               cmd;
   logic [REQ_SIZE_W-1:0] request_size;
   logic [IDX_W-1:0]      block_index;

   modport source (output valid, cmd, request_size, block_index, input ready);
   modport sink (input valid, cmd, request_size, block_index, output ready);
endinterface

interface fbpa_rsp_if import fbpa_pkg::*; ();
   logic                   valid;
   logic                   ready;
   status_type             status;
   logic [IDX_W-1:0]       granted_index;
   logic [IDX_W-1:0]       used_blocks;
   logic [IDX_W-1:0]       free_blocks;
   logic [ALLOC_CNT_W-1:0] allocation_count;
   logic [BYTES_W-1:0]     total_allocated;
   logic [USAGE_W-1:0]     current_usage;
   logic [USAGE_W-1:0]     peak_usage;

   modport source (output valid, status, granted_index, used_blocks, free_blocks,
      allocation_count, total_allocated, current_usage, peak_usage, input ready);
   modport sink (input valid, status, granted_index, used_blocks, free_blocks,
      allocation_count, total_allocated, current_usage, peak_usage, output ready);
endinterface

/* sv/fbpa_free_list.sv */
`include "fixed_block_pool_allocator_defines.svh"

module fbpa_free_list import fbpa_pkg::*; #(
   parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  fl_req_type fl_req,
   output fl_rsp_type fl_rsp
);

   localparam int ADDR_W = $clog2(POOL_DEPTH);

   logic [IDX_W-1:0]  link_mem [POOL_DEPTH];
   logic [IDX_W-1:0]  head_ff;
   logic [IDX_W-1:0]  head_in;
   logic [IDX_W-1:0]  fresh_ff;
   logic [IDX_W-1:0]  fresh_in;
   logic [IDX_W-1:0]  link_ff;
   logic              stack_ok;
   logic              fresh_ok;
   logic              pop;
   logic              take_fresh;
   logic              push;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;

   always_comb begin
      stack_ok   = (head_ff < fl_req.cnt) ||
                   ((head_ff != NULL_IDX) && (int'(head_ff) < POOL_DEPTH));
      fresh_ok   = fresh_ff < fl_req.cnt;
      pop        = fl_req.alloc && stack_ok;
      take_fresh = fl_req.alloc && !stack_ok && fresh_ok;
      push       = fl_req.free && (fl_req.idx < fl_req.cnt);

      head_in = head_ff;
      if (fl_req.clear) begin
         head_in = NULL_IDX;
      end else if (pop) begin
         head_in = link_ff;
      end else if (push) begin
         head_in = fl_req.idx;
      end

      fresh_in = fresh_ff;
      if (fl_req.clear) begin
         fresh_in = '0;
      end else if (take_fresh) begin
         fresh_in = fresh_ff + 9'd1;
      end

      fl_rsp.granted = pop || take_fresh;
      fl_rsp.pushed  = push;
      if (pop) begin
         fl_rsp.index = head_ff;
      end else if (take_fresh) begin
         fl_rsp.index = fresh_ff;
      end else begin
         fl_rsp.index = NULL_IDX;
      end

      rd_addr = ADDR_W'(head_in);
      wr_addr = ADDR_W'(fl_req.idx);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= NULL_IDX;
         fresh_ff <= '0;
      end else begin
         head_ff  <= head_in;
         fresh_ff <= fresh_in;
      end
   end

   // link of the next head, forwarded on a push
   always_ff @(posedge clock) begin
      if (push) begin
         link_mem[wr_addr] <= head_ff;
      end
      link_ff <= push ? head_ff : link_mem[rd_addr];
   end

   `FBPA_ASSERT_NEXT(a_push_head, clock, reset, push, head_ff == $past(fl_req.idx), "push lost")
   `FBPA_ASSERT_NEXT(a_pop_head, clock, reset, pop, head_ff == $past(link_ff), "pop link bad")
   `FBPA_ASSERT_NEXT(a_clear, clock, reset, fl_req.clear, (head_ff == NULL_IDX) && (fresh_ff == '0), "clear failed")

endmodule

/* sv/fixed_block_pool_allocator.sv */
// Fixed block pool allocator: hands out and takes back equal blocks from a LIFO free list.
// req_bus carries commands (allocate, free, reset pool, no-op) with a valid/ready transfer;
// rsp_bus returns one result per command: status, granted block and the usage statistics.
// csr_wr_en/csr_index/csr_wr_data set block size (index 0) and block count (index 1);
// write them only while no command is in flight.
// A command accepted into the input register passes through the free list, and its result
// is registered in the result register, from which rsp_bus transfers it.
// Throughput: one command per cycle while the receiver takes results; the prefetched link
// of the stack head lets allocations follow each other without a gap.
// Reset (synchronous) empties the freed-block stack, restarts the fresh counter at block 0,
// clears all statistics and loads block size 64 and block count 256. No memory sweep.
// When the receiver stalls, the result holds, one more command is taken into the input
// register and then req_bus.ready drops until the result is taken.
`include "fixed_block_pool_allocator_defines.svh"

module fixed_block_pool_allocator import fbpa_pkg::*; #(
   parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   fbpa_req_if.sink              req_bus,
   fbpa_rsp_if.source            rsp_bus,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   logic [SIZE_W-1:0]      block_size_ff;
   logic [IDX_W-1:0]       block_count_ff;
   logic [IDX_W-1:0]       cnt;

   logic                   in_valid_ff;
   cmd_type                in_cmd_ff;
   logic [REQ_SIZE_W-1:0]  in_size_ff;
   logic [IDX_W-1:0]       in_idx_ff;

   logic                   out_valid_ff;
   status_type             out_status_ff;
   status_type             out_status_in;
   logic [IDX_W-1:0]       out_granted_ff;

   logic [IDX_W-1:0]       used_ff;
   logic [IDX_W-1:0]       used_in;
   logic [ALLOC_CNT_W-1:0] alloc_cnt_ff;
   logic [ALLOC_CNT_W-1:0] alloc_cnt_in;
   logic [BYTES_W-1:0]     bytes_ff;
   logic [BYTES_W-1:0]     bytes_in;
   logic [USAGE_W-1:0]     usage_ff;
   logic [USAGE_W-1:0]     usage_in;
   logic [USAGE_W-1:0]     peak_ff;
   logic [USAGE_W-1:0]     peak_in;

   logic                   advance;
   logic                   too_large;
   logic                   grant_ok;
   logic [BYTES_W:0]       bytes_sum;
   logic [USAGE_W:0]       usage_sum;
   fl_req_type             fl_req;
   fl_rsp_type             fl_rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff  <= BLOCK_SIZE_RST;
         block_count_ff <= BLOCK_COUNT_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_BLOCK_SIZE: begin
               block_size_ff <= csr_wr_data[SIZE_W-1:0];
            end
            REG_BLOCK_COUNT: begin
               block_count_ff <= csr_wr_data[IDX_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign cnt = (int'(block_count_ff) > POOL_DEPTH) ? IDX_W'(POOL_DEPTH) : block_count_ff;

   assign advance       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_cmd_ff  <= req_bus.cmd;
         in_size_ff <= req_bus.request_size;
         in_idx_ff  <= req_bus.block_index;
      end
   end

   always_comb begin
      too_large    = in_size_ff > {1'b0, block_size_ff};
      fl_req.alloc = advance && (in_cmd_ff == CMD_ALLOC) && !too_large;
      fl_req.free  = advance && (in_cmd_ff == CMD_FREE);
      fl_req.clear = advance && (in_cmd_ff == CMD_RESET);
      fl_req.idx   = in_idx_ff;
      fl_req.cnt   = cnt;
   end

   fbpa_free_list #(
      .POOL_DEPTH (POOL_DEPTH)
   ) u_free_list (
      .clock  (clock),
      .reset  (reset),
      .fl_req (fl_req),
      .fl_rsp (fl_rsp)
   );

   always_comb begin
      grant_ok  = fl_rsp.granted && (fl_rsp.index != NULL_IDX);
      bytes_sum = {1'b0, bytes_ff} + (BYTES_W + 1)'(block_size_ff);
      usage_sum = {1'b0, usage_ff} + (USAGE_W + 1)'(block_size_ff);

      out_status_in = ST_DONE;
      if (in_cmd_ff == CMD_ALLOC) begin
         if (too_large) begin
            out_status_in = ST_TOO_LARGE;
         end else if (!fl_rsp.granted) begin
            out_status_in = ST_EMPTY;
         end
      end

      used_in      = used_ff;
      alloc_cnt_in = alloc_cnt_ff;
      bytes_in     = bytes_ff;
      usage_in     = usage_ff;
      if (grant_ok) begin
         if (used_ff != USED_MAX) begin
            used_in = used_ff + 9'd1;
         end
         if (alloc_cnt_ff != '1) begin
            alloc_cnt_in = alloc_cnt_ff + 32'd1;
         end
         bytes_in = bytes_sum[BYTES_W] ? '1 : bytes_sum[BYTES_W-1:0];
         usage_in = usage_sum[USAGE_W] ? '1 : usage_sum[USAGE_W-1:0];
      end else if (fl_rsp.pushed) begin
         if (used_ff != '0) begin
            used_in = used_ff - 9'd1;
         end
         if (usage_ff >= USAGE_W'(block_size_ff)) begin
            usage_in = usage_ff - USAGE_W'(block_size_ff);
         end
      end else if (fl_req.clear) begin
         used_in  = '0;
         usage_in = '0;
      end
      peak_in = (usage_in > peak_ff) ? usage_in : peak_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         used_ff      <= '0;
         alloc_cnt_ff <= '0;
         bytes_ff     <= '0;
         usage_ff     <= '0;
         peak_ff      <= '0;
      end else begin
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
         used_ff      <= used_in;
         alloc_cnt_ff <= alloc_cnt_in;
         bytes_ff     <= bytes_in;
         usage_ff     <= usage_in;
         peak_ff      <= peak_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_status_ff  <= out_status_in;
         out_granted_ff <= fl_rsp.index;
      end
   end

   assign rsp_bus.valid            = out_valid_ff;
   assign rsp_bus.status           = out_status_ff;
   assign rsp_bus.granted_index    = out_granted_ff;
   assign rsp_bus.used_blocks      = used_ff;
   assign rsp_bus.free_blocks      = (cnt > used_ff) ? (cnt - used_ff) : '0;
   assign rsp_bus.allocation_count = alloc_cnt_ff;
   assign rsp_bus.total_allocated  = bytes_ff;
   assign rsp_bus.current_usage    = usage_ff;
   assign rsp_bus.peak_usage       = peak_ff;

   `FBPA_ASSERT_IMPL(a_grant_status, clock, reset, rsp_bus.valid && (rsp_bus.granted_index != NULL_IDX), rsp_bus.status == ST_DONE, "grant without done status")
   `FBPA_ASSERT_IMPL(a_peak_bound, clock, reset, 1'b1, peak_ff >= usage_ff, "peak below usage")
   `FBPA_ASSERT_NEXT(a_accept_held, clock, reset, req_bus.valid && req_bus.ready, in_valid_ff, "accepted command dropped")

endmodule

/* tb/sv/fixed_block_pool_allocator_checker.sv */
`timescale 1ns / 1ps

module fixed_block_pool_allocator_checker import fbpa_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   fbpa_req_if                   req_bus,
   fbpa_rsp_if                   rsp_bus,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   output int                    mismatch_count,
   output int                    pending_count
);

   localparam int DEPTH = POOL_DEPTH_DEF;

   typedef struct packed {
      status_type             status;
      logic [IDX_W-1:0]       granted_index;
      logic [IDX_W-1:0]       used_blocks;
      logic [IDX_W-1:0]       free_blocks;
      logic [ALLOC_CNT_W-1:0] allocation_count;
      logic [BYTES_W-1:0]     total_allocated;
      logic [USAGE_W-1:0]     current_usage;
      logic [USAGE_W-1:0]     peak_usage;
   } pool_view_type;

   pool_view_type          expected_views[$];

   logic [IDX_W-1:0]       next_link[DEPTH];
   logic [IDX_W-1:0]       stack_top;
   logic [IDX_W-1:0]       fresh_idx;
   logic [IDX_W-1:0]       used_cnt;
   logic [ALLOC_CNT_W-1:0] grant_total;
   logic [BYTES_W-1:0]     byte_total;
   logic [USAGE_W-1:0]     usage_cur;
   logic [USAGE_W-1:0]     usage_max;
   logic [SIZE_W-1:0]      blk_size;
   logic [IDX_W-1:0]       blk_count;

   function automatic logic [IDX_W-1:0] live_count();
      return (blk_count > IDX_W'(DEPTH)) ? IDX_W'(DEPTH) : blk_count;
   endfunction

   function automatic pool_view_type apply_pool_cmd(cmd_type cmd,
      logic [REQ_SIZE_W-1:0] req_size, logic [IDX_W-1:0] idx);
      pool_view_type    view;
      logic [IDX_W-1:0] cnt;
      logic [BYTES_W:0] byte_sum;
      logic [USAGE_W:0] usage_sum;
      cnt = live_count();
      view = '0;
      view.status = ST_DONE;
      view.granted_index = NULL_IDX;
      case (cmd)
         CMD_ALLOC: begin
            if (req_size > {1'b0, blk_size}) begin
               view.status = ST_TOO_LARGE;
            end else if (stack_top != NULL_IDX) begin
               view.granted_index = stack_top;
               stack_top = next_link[stack_top[7:0]];
            end else if (fresh_idx < cnt) begin
               view.granted_index = fresh_idx;
               fresh_idx = fresh_idx + IDX_W'(1);
            end else begin
               view.status = ST_EMPTY;
            end
            if (view.granted_index != NULL_IDX) begin
               if (used_cnt != USED_MAX) used_cnt = used_cnt + IDX_W'(1);
               if (grant_total != '1) grant_total = grant_total + ALLOC_CNT_W'(1);
               byte_sum = {1'b0, byte_total} + (BYTES_W + 1)'(blk_size);
               byte_total = byte_sum[BYTES_W] ? '1 : byte_sum[BYTES_W-1:0];
               usage_sum = {1'b0, usage_cur} + (USAGE_W + 1)'(blk_size);
               usage_cur = usage_sum[USAGE_W] ? '1 : usage_sum[USAGE_W-1:0];
               if (usage_cur > usage_max) usage_max = usage_cur;
            end
         end
         CMD_FREE: begin
            // null and out-of-range indices fall through untouched
            if (idx < cnt) begin
               next_link[idx[7:0]] = stack_top;
               stack_top = idx;
               if (used_cnt != '0) used_cnt = used_cnt - IDX_W'(1);
               if (usage_cur >= USAGE_W'(blk_size)) usage_cur = usage_cur - USAGE_W'(blk_size);
            end
         end
         CMD_RESET: begin
            stack_top = NULL_IDX;
            fresh_idx = '0;
            used_cnt = '0;
            usage_cur = '0;
         end
         default: begin
         end
      endcase
      cnt = live_count();
      view.used_blocks = used_cnt;
      view.free_blocks = (cnt > used_cnt) ? cnt - used_cnt : '0;
      view.allocation_count = grant_total;
      view.total_allocated = byte_total;
      view.current_usage = usage_cur;
      view.peak_usage = usage_max;
      return view;
   endfunction

   task automatic check_field(string field, logic [BYTES_W-1:0] want, logic [BYTES_W-1:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      pool_view_type want;
      if (reset) begin
         expected_views.delete();
         stack_top = NULL_IDX;
         fresh_idx = '0;
         used_cnt = '0;
         grant_total = '0;
         byte_total = '0;
         usage_cur = '0;
         usage_max = '0;
         blk_size = BLOCK_SIZE_RST;
         blk_count = BLOCK_COUNT_RST;
         mismatch_count = 0;
      end else begin
         if (csr_wr_en) begin
            if (csr_index == REG_BLOCK_SIZE) begin
               blk_size = csr_wr_data[SIZE_W-1:0];
            end else if (csr_index == REG_BLOCK_COUNT) begin
               blk_count = csr_wr_data[IDX_W-1:0];
            end
         end
         // results first, so a command taken at this edge never matches itself
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_views.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: result transfer with nothing expected", $realtime);
            end else begin
               want = expected_views.pop_front();
               check_field("status", want.status, rsp_bus.status);
               check_field("granted_index", want.granted_index, rsp_bus.granted_index);
               check_field("used_blocks", want.used_blocks, rsp_bus.used_blocks);
               check_field("free_blocks", want.free_blocks, rsp_bus.free_blocks);
               check_field("allocation_count", want.allocation_count,
                  rsp_bus.allocation_count);
               check_field("total_allocated", want.total_allocated, rsp_bus.total_allocated);
               check_field("current_usage", want.current_usage, rsp_bus.current_usage);
               check_field("peak_usage", want.peak_usage, rsp_bus.peak_usage);
            end
         end
         if (req_bus.valid && req_bus.ready)
            expected_views.push_back(apply_pool_cmd(req_bus.cmd, req_bus.request_size,
               req_bus.block_index));
      end
      pending_count = expected_views.size();
   end

endmodule

/* tb/sv/fixed_block_pool_allocator_tb.sv */
`timescale 1ns / 1ps

module fixed_block_pool_allocator_tb;
   import fbpa_pkg::*;

   localparam int HOLD_CYCLES = 64;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;
   int                    mismatch_count;
   int                    pending_count;

   int                    req_idle_pct = 0;
   int                    rsp_idle_pct = 0;
   bit                    hold_pending = 1'b0;
   int                    cur_size = 64;
   int                    cur_count = 256;
   logic [IDX_W-1:0]      live_blocks[$];

   fbpa_req_if req_bus ();
   fbpa_rsp_if rsp_bus ();

   fixed_block_pool_allocator i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   fixed_block_pool_allocator_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("** fixed_block_pool_allocator: FAILED **");
      $finish;
   end

   // granted blocks, so that most frees return something really handed out
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready && rsp_bus.status == ST_DONE &&
          rsp_bus.granted_index != NULL_IDX)
         live_blocks.push_back(rsp_bus.granted_index);
   end

   initial begin : result_sink
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (rsp_idle_pct != 0 && $urandom_range(0, 99) < rsp_idle_pct) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic send_cmd(cmd_type cmd, logic [REQ_SIZE_W-1:0] req_size,
      logic [IDX_W-1:0] idx);
      if (req_idle_pct != 0 && $urandom_range(0, 99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.cmd <= cmd;
      req_bus.request_size <= req_size;
      req_bus.block_index <= idx;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0 || rsp_bus.valid) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic set_pool_geometry(int size, int count);
      csr_wr_en <= 1'b1;
      csr_index <= REG_BLOCK_SIZE;
      csr_wr_data <= CSR_DATA_W'(size);
      @(posedge clock);
      csr_index <= REG_BLOCK_COUNT;
      csr_wr_data <= CSR_DATA_W'(count);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_size = size;
      cur_count = count;
   endtask

   task automatic send_random(int n);
      int                    pick;
      int                    eff;
      int                    j;
      logic [REQ_SIZE_W-1:0] req_size;
      logic [IDX_W-1:0]      idx;
      for (int i = 0; i < n; i++) begin
         eff = (cur_count > POOL_DEPTH_DEF) ? POOL_DEPTH_DEF : cur_count;
         pick = $urandom_range(0, 99);
         req_size = REQ_SIZE_W'($urandom_range(0, 131071));
         idx = IDX_W'($urandom_range(0, 511));
         if (pick < 48) begin
            pick = $urandom_range(0, 99);
            if (pick < 85) req_size = REQ_SIZE_W'($urandom_range(0, cur_size));
            else if (pick < 95) req_size = REQ_SIZE_W'($urandom_range(cur_size + 1, 65536));
            send_cmd(CMD_ALLOC, req_size, idx);
         end else if (pick < 94) begin
            pick = $urandom_range(0, 99);
            if (live_blocks.size() > 0 && pick < 80) begin
               j = $urandom_range(0, live_blocks.size() - 1);
               idx = live_blocks[j];
               live_blocks.delete(j);
            end else if (eff > 0 && pick < 90) begin
               idx = IDX_W'($urandom_range(0, eff - 1));
            end
            send_cmd(CMD_FREE, req_size, idx);
         end else if (pick < 97) begin
            live_blocks.delete();
            send_cmd(CMD_RESET, req_size, idx);
         end else begin
            send_cmd(CMD_NOP, req_size, idx);
         end
      end
   endtask

   initial begin : stimulus
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.cmd <= CMD_NOP;
      req_bus.request_size <= '0;
      req_bus.block_index <= '0;
      csr_wr_en <= 1'b0;
      csr_index <= REG_BLOCK_SIZE;
      csr_wr_data <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset geometry: extremes of size, double free, null and out-of-range frees
      req_idle_pct = 30;
      rsp_idle_pct = 30;
      send_cmd(CMD_ALLOC, 17'd0, 9'd0);
      send_cmd(CMD_ALLOC, 17'd64, 9'd511);
      send_cmd(CMD_ALLOC, 17'd65, 9'd0);
      send_cmd(CMD_ALLOC, 17'd65536, 9'd0);
      send_cmd(CMD_ALLOC, 17'd131071, 9'd0);
      send_cmd(CMD_FREE, 17'd0, 9'd1);
      send_cmd(CMD_FREE, 17'd0, 9'd1);
      send_cmd(CMD_ALLOC, 17'd1, 9'd0);
      send_cmd(CMD_ALLOC, 17'd1, 9'd0);
      send_cmd(CMD_FREE, 17'd0, NULL_IDX);
      send_cmd(CMD_FREE, 17'd0, 9'd300);
      send_cmd(CMD_FREE, 17'd131071, 9'd511);
      send_cmd(CMD_NOP, 17'd131071, 9'd511);
      send_cmd(CMD_FREE, 17'd0, 9'd0);
      send_cmd(CMD_RESET, 17'd0, 9'd0);
      send_cmd(CMD_ALLOC, 17'd0, 9'd0);

      // tiny pool of largest blocks, runs empty
      wait_idle();
      set_pool_geometry(65535, 3);
      send_cmd(CMD_RESET, 17'd0, 9'd0);
      repeat (4) send_cmd(CMD_ALLOC, 17'd65535, 9'd0);
      send_cmd(CMD_FREE, 17'd0, 9'd2);
      send_cmd(CMD_FREE, 17'd0, 9'd1);
      send_cmd(CMD_ALLOC, 17'd65536, 9'd0);

      // count lowered under stacked blocks
      wait_idle();
      set_pool_geometry(65535, 1);
      repeat (3) send_cmd(CMD_ALLOC, 17'd7, 9'd0);
      send_cmd(CMD_FREE, 17'd0, 9'd0);
      send_cmd(CMD_FREE, 17'd0, 9'd2);

      // zero count: always empty
      wait_idle();
      set_pool_geometry(65535, 0);
      send_cmd(CMD_RESET, 17'd0, 9'd0);
      send_cmd(CMD_ALLOC, 17'd0, 9'd0);
      send_cmd(CMD_FREE, 17'd0, 9'd0);

      // self-linked block after a double free drives the counters into saturation
      wait_idle();
      set_pool_geometry(65535, 256);
      req_idle_pct = 10;
      rsp_idle_pct = 10;
      send_cmd(CMD_RESET, 17'd0, 9'd0);
      send_cmd(CMD_ALLOC, 17'd0, 9'd0);
      send_cmd(CMD_FREE, 17'd0, 9'd0);
      send_cmd(CMD_FREE, 17'd0, 9'd0);
      repeat (520) send_cmd(CMD_ALLOC, 17'($urandom_range(0, 65535)), 9'($urandom_range(0, 511)));

      for (int p = 0; p < 8; p++) begin
         wait_idle();
         live_blocks.delete();
         case (p)
            0: set_pool_geometry(64, 256);
            1: set_pool_geometry(1, 1);
            2: set_pool_geometry(65535, 256);
            3: set_pool_geometry($urandom_range(1, 65535), $urandom_range(1, 16));
            4: set_pool_geometry(512, 2);
            5: set_pool_geometry($urandom_range(1, 65535), 256);
            6: set_pool_geometry(1, 256);
            default: set_pool_geometry($urandom_range(1, 65535), $urandom_range(1, 256));
         endcase
         send_cmd(CMD_RESET, 17'($urandom_range(0, 131071)), 9'($urandom_range(0, 511)));
         req_idle_pct = (p == 4 || p == 7) ? 0 : 25;
         rsp_idle_pct = (p == 4 || p == 7) ? 0 : 25;
         if (p == 2) begin
            req_idle_pct = 0;
            send_random(40);
            hold_pending = 1'b1;
            send_random(65);
         end else begin
            send_random(105);
         end
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("** fixed_block_pool_allocator: PASSED **");
      end else begin
         $display("** fixed_block_pool_allocator: FAILED **");
      end
      $finish;
   end

endmodule

/* fixed_block_pool_allocator.f */
+incdir+sv
sv/fbpa_pkg.sv
sv/fbpa_if.sv
sv/fbpa_free_list.sv
sv/fixed_block_pool_allocator.sv
tb/sv/fixed_block_pool_allocator_checker.sv
tb/sv/fixed_block_pool_allocator_tb.sv
